### design/tcc_pkg.sv
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int ACC_W = 15;
    localparam int MAG_W = 17;
    localparam int SQ_W = 28;
    localparam int RAD_W = 44;
    localparam int ROOT_W = 22;
    localparam int ISQRT_STEPS = 22;
    localparam int INNER_FRAC = 20;
    localparam int Z_W = 31;
    localparam int CX_W = 34;
    localparam int NORM_W = 64;
    localparam int NORM_STEPS = 6;
    localparam int HALF_TURN = 180;
    localparam int QUARTER_TURN = 90;
    localparam int FULL_TURN = 360;

    typedef enum logic [2:0] {
        CFG_ACC_X = 3'd0,
        CFG_ACC_Y = 3'd1,
        CFG_ACC_Z = 3'd2,
        CFG_MAG_X = 3'd3,
        CFG_MAG_Y = 3'd4,
        CFG_MAG_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
        logic signed [MAG_W-1:0] mx;
        logic signed [MAG_W-1:0] my;
        logic signed [MAG_W-1:0] mz;
        logic                    inv;
    } side_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic signed [ACC_W-1:0] az;
        logic [ROOT_W-1:0]       hh;
        logic                    inv;
    } carry_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // atan(2^-i) in degrees, 20 fractional bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 31'sd47185920;
            5'd1:    v = 31'sd27855475;
            5'd2:    v = 31'sd14718068;
            5'd3:    v = 31'sd7471121;
            5'd4:    v = 31'sd3750058;
            5'd5:    v = 31'sd1876857;
            5'd6:    v = 31'sd938658;
            5'd7:    v = 31'sd469357;
            5'd8:    v = 31'sd234682;
            5'd9:    v = 31'sd117342;
            5'd10:   v = 31'sd58671;
            5'd11:   v = 31'sd29335;
            5'd12:   v = 31'sd14668;
            5'd13:   v = 31'sd7334;
            5'd14:   v = 31'sd3667;
            5'd15:   v = 31'sd1833;
            5'd16:   v = 31'sd917;
            5'd17:   v = 31'sd458;
            5'd18:   v = 31'sd229;
            5'd19:   v = 31'sd115;
            5'd20:   v = 31'sd57;
            5'd21:   v = 31'sd29;
            5'd22:   v = 31'sd14;
            5'd23:   v = 31'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/tilt_compensated_compass_top.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled; the two 22-step
// square root chains and the three CORDIC chains are fully pipelined, so each stage holds a different request.
// A stalled result holds every stage; s_ready is high when m_ready is high or no result is held.
// Reset (aresetn low, synchronous) clears the offsets and all valid flags.

module tilt_compensated_compass_top #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [13:0] s_accel_x,
    input  logic signed [13:0] s_accel_y,
    input  logic signed [13:0] s_accel_z,
    input  logic signed [15:0] s_magnet_x,
    input  logic signed [15:0] s_magnet_y,
    input  logic signed [15:0] s_magnet_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [13:0] m_pitch_angle,
    output logic signed [14:0] m_roll_angle,
    output logic [14:0]        m_heading_angle,
    output logic               m_invalid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = tcc_pkg::ACC_W;
    localparam int MW = tcc_pkg::MAG_W;
    localparam int ZW = tcc_pkg::Z_W;
    localparam int RW = tcc_pkg::RAD_W;
    localparam int QW = tcc_pkg::ROOT_W;
    localparam int NW = tcc_pkg::NORM_W;
    localparam int SQ = tcc_pkg::ISQRT_STEPS;
    localparam int ANG_LAT = CORDIC_STAGES + 10;
    localparam int LAT = 32 + ANG_LAT;
    localparam int RS = tcc_pkg::INNER_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF_R = ZW'(1 << (RS - 1));
    localparam logic signed [ZW-1:0] PLIM = ZW'(tcc_pkg::QUARTER_TURN << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] HLIM = ZW'(tcc_pkg::HALF_TURN << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] FULL = ZW'(tcc_pkg::FULL_TURN << ANGLE_FRAC_BITS);

    function automatic logic signed [ZW-1:0] round_sat(input logic signed [ZW-1:0] z,
                                                       input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] r;
        r = (z + HALF_R) >>> RS;
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    logic en;
    logic [LAT-1:0] vld_reg;

    // offsets
    logic signed [7:0]  off_ax_reg, off_ay_reg, off_az_reg;
    logic signed [15:0] off_mx_reg, off_my_reg, off_mz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_ax_reg <= '0;
            off_ay_reg <= '0;
            off_az_reg <= '0;
            off_mx_reg <= '0;
            off_my_reg <= '0;
            off_mz_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tcc_pkg::CFG_ACC_X: off_ax_reg <= cfg_data[7:0];
                tcc_pkg::CFG_ACC_Y: off_ay_reg <= cfg_data[7:0];
                tcc_pkg::CFG_ACC_Z: off_az_reg <= cfg_data[7:0];
                tcc_pkg::CFG_MAG_X: off_mx_reg <= cfg_data;
                tcc_pkg::CFG_MAG_Y: off_my_reg <= cfg_data;
                tcc_pkg::CFG_MAG_Z: off_mz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: every stage advances together
    assign en      = m_ready || !vld_reg[LAT-1];
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: remove offsets (magnet y is negated here)
    tcc_pkg::side_t s1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.ax  <= AW'(s_accel_x) - AW'(off_ax_reg);
            s1_reg.ay  <= AW'(s_accel_y) - AW'(off_ay_reg);
            s1_reg.az  <= AW'(s_accel_z) - AW'(off_az_reg);
            s1_reg.mx  <= MW'(s_magnet_x) - MW'(off_mx_reg);
            s1_reg.my  <= MW'(off_my_reg) - MW'(s_magnet_y);
            s1_reg.mz  <= MW'(s_magnet_z) - MW'(off_mz_reg);
            s1_reg.inv <= 1'b0;
        end
    end

    // stage 2: squares, zero vector check
    logic signed [2*AW-1:0] sqx, sqy, sqz;
    logic [tcc_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    tcc_pkg::side_t s2_next, s2_reg;

    assign sqx = s1_reg.ax * s1_reg.ax;
    assign sqy = s1_reg.ay * s1_reg.ay;
    assign sqz = s1_reg.az * s1_reg.az;

    always_comb begin
        s2_next     = s1_reg;
        s2_next.inv = (s1_reg.ax == '0 && s1_reg.ay == '0 && s1_reg.az == '0)
                   || (s1_reg.mx == '0 && s1_reg.my == '0 && s1_reg.mz == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= sqx[tcc_pkg::SQ_W-1:0];
            sqy_reg <= sqy[tcc_pkg::SQ_W-1:0];
            sqz_reg <= sqz[tcc_pkg::SQ_W-1:0];
            s2_reg  <= s2_next;
        end
    end

    // stage 3: squared sums
    logic [tcc_pkg::SQ_W-1:0] ssh_reg, ssn_reg;
    tcc_pkg::side_t s3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ssh_reg <= sqy_reg + sqz_reg;
            ssn_reg <= sqx_reg + sqy_reg + sqz_reg;
            s3_reg  <= s2_reg;
        end
    end

    // square root chains, one result bit per cell
    logic [RW-1:0] vh [0:SQ];
    logic [RW-1:0] rh [0:SQ];
    logic [RW-1:0] vn [0:SQ];
    logic [RW-1:0] rn [0:SQ];
    tcc_pkg::side_t sd_reg [1:SQ];

    assign vh[0] = {ssh_reg, 16'h0000};
    assign rh[0] = '0;
    assign vn[0] = {ssn_reg, 16'h0000};
    assign rn[0] = '0;

    for (genvar g = 0; g < SQ; g++) begin : g_sqrt
        tcc_sqrt_cell #(
            .K(SQ - 1 - g)
        ) u_h (
            .aclk  (aclk),
            .en    (en),
            .v_in  (vh[g]),
            .r_in  (rh[g]),
            .v_out (vh[g+1]),
            .r_out (rh[g+1])
        );
        tcc_sqrt_cell #(
            .K(SQ - 1 - g)
        ) u_n (
            .aclk  (aclk),
            .en    (en),
            .v_in  (vn[g]),
            .r_in  (rn[g]),
            .v_out (vn[g+1]),
            .r_out (rn[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[1] <= s3_reg;
            for (int k = 2; k <= SQ; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // P1: first products of the tilt compensation
    logic [QW-1:0]          hh, nn;
    tcc_pkg::side_t         sq_side;
    logic signed [QW:0]     hs, aa, ayy, azz, zsel, hm;
    logic signed [AW-1:0]   azabs;
    logic signed [39:0]     mxh, mza, mxa, mzh, myz;
    logic signed [39:0]     mxh1_reg, mza1_reg, mxa1_reg, mzh1_reg, myz1_reg;
    logic signed [QW:0]     hm1_reg, ayy1_reg;
    logic [QW-1:0]          nn1_reg;
    tcc_pkg::carry_t        c1_reg, c2_reg, c3_reg, c4_reg;

    assign hh      = rh[SQ][QW-1:0];
    assign nn      = rn[SQ][QW-1:0];
    assign sq_side = sd_reg[SQ];
    assign hs      = signed'({1'b0, hh});
    assign aa      = {sq_side.ax, 8'h00};
    assign ayy     = {sq_side.ay, 8'h00};
    assign azabs   = (sq_side.az < 0) ? -sq_side.az : sq_side.az;
    assign azz     = {azabs, 8'h00};
    // level axes: roll sine 0, cosine 1
    assign zsel    = (hh == '0) ? (QW + 1)'(1) : azz;
    assign hm      = (hh == '0) ? (QW + 1)'(1) : hs;
    assign mxh     = sq_side.mx * hs;
    assign mza     = sq_side.mz * aa;
    assign mxa     = sq_side.mx * aa;
    assign mzh     = sq_side.mz * hs;
    assign myz     = sq_side.my * zsel;

    always_ff @(posedge aclk) begin
        if (en) begin
            mxh1_reg   <= mxh;
            mza1_reg   <= mza;
            mxa1_reg   <= mxa;
            mzh1_reg   <= mzh;
            myz1_reg   <= myz;
            hm1_reg    <= hm;
            ayy1_reg   <= ayy;
            nn1_reg    <= nn;
            c1_reg.ax  <= sq_side.ax;
            c1_reg.ay  <= sq_side.ay;
            c1_reg.az  <= sq_side.az;
            c1_reg.hh  <= hh;
            c1_reg.inv <= sq_side.inv;
        end
    end

    // P2: differences
    logic signed [40:0] d1, d2, d1_reg, d2_reg;
    logic signed [39:0] myz2_reg;
    logic signed [QW:0] hm2_reg, ayy2_reg;
    logic [QW-1:0]      nn2_reg;

    assign d1 = mxh1_reg - mza1_reg;
    assign d2 = -mxa1_reg - mzh1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg   <= d1;
            d2_reg   <= d2;
            myz2_reg <= myz1_reg;
            hm2_reg  <= hm1_reg;
            ayy2_reg <= ayy1_reg;
            nn2_reg  <= nn1_reg;
            c2_reg   <= c1_reg;
        end
    end

    // P3: wide products split into partial products
    logic signed [QW:0] nns;
    logic signed [44:0] cxl, t1l;
    logic signed [42:0] cxh, t1h, t2h;
    logic signed [43:0] t2l;
    logic signed [44:0] cxl_reg, t1l_reg;
    logic signed [42:0] cxh_reg, t1h_reg, t2h_reg;
    logic signed [43:0] t2l_reg;

    assign nns = signed'({1'b0, nn2_reg});
    assign cxl = hm2_reg * signed'({1'b0, d1_reg[20:0]});
    assign cxh = hm2_reg * signed'(d1_reg[40:21]);
    assign t1l = ayy2_reg * signed'({1'b0, d2_reg[20:0]});
    assign t1h = ayy2_reg * signed'(d2_reg[40:21]);
    assign t2l = nns * signed'({1'b0, myz2_reg[19:0]});
    assign t2h = nns * signed'(myz2_reg[39:20]);

    always_ff @(posedge aclk) begin
        if (en) begin
            cxl_reg <= cxl;
            cxh_reg <= cxh;
            t1l_reg <= t1l;
            t1h_reg <= t1h;
            t2l_reg <= t2l;
            t2h_reg <= t2h;
            c3_reg  <= c2_reg;
        end
    end

    // P4: recombine partial products
    logic signed [NW-1:0] cx4, t14, t24, cx4_reg, t14_reg, t24_reg;

    assign cx4 = (cxh_reg <<< 21) + cxl_reg;
    assign t14 = (t1h_reg <<< 21) + t1l_reg;
    assign t24 = (t2h_reg <<< 20) + t2l_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx4_reg <= cx4;
            t14_reg <= t14;
            t24_reg <= t24;
            c4_reg  <= c3_reg;
        end
    end

    // P5: atan2 operands for all three angles
    logic signed [NW-1:0] hy, py, ry, rx, px;
    logic signed [NW-1:0] hy_reg, hx_reg, ry_reg, rx_reg, py_reg, px_reg;
    logic                 inv5_reg;

    assign hy = -t14_reg - t24_reg;
    assign ry = c4_reg.ay;
    assign rx = c4_reg.az;
    assign py = -(NW'(c4_reg.ax) <<< 8);
    assign px = signed'(NW'(c4_reg.hh));

    always_ff @(posedge aclk) begin
        if (en) begin
            hy_reg   <= hy;
            hx_reg   <= cx4_reg;
            ry_reg   <= ry;
            rx_reg   <= rx;
            py_reg   <= py;
            px_reg   <= px;
            inv5_reg <= c4_reg.inv;
        end
    end

    logic signed [ZW-1:0] z_roll, z_pitch, z_head;

    tcc_angle #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk  (aclk),
        .en    (en),
        .y_in  (ry_reg),
        .x_in  (rx_reg),
        .z_out (z_roll)
    );

    tcc_angle #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk  (aclk),
        .en    (en),
        .y_in  (py_reg),
        .x_in  (px_reg),
        .z_out (z_pitch)
    );

    tcc_angle #(.STAGES(CORDIC_STAGES)) u_head (
        .aclk  (aclk),
        .en    (en),
        .y_in  (hy_reg),
        .x_in  (hx_reg),
        .z_out (z_head)
    );

    logic invd_reg [1:ANG_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            invd_reg[1] <= inv5_reg;
            for (int k = 2; k <= ANG_LAT; k++) begin
                invd_reg[k] <= invd_reg[k-1];
            end
        end
    end

    // round and saturate
    logic signed [ZW-1:0] rp_reg, rr_reg, rh_reg;
    logic                 invr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rp_reg   <= round_sat(z_pitch, PLIM);
            rr_reg   <= round_sat(z_roll, HLIM);
            rh_reg   <= round_sat(z_head, HLIM);
            invr_reg <= invd_reg[ANG_LAT];
        end
    end

    // wrap heading into one turn, output register
    logic signed [ZW-1:0] hwrap;
    logic signed [13:0]   m_pitch_reg;
    logic signed [14:0]   m_roll_reg;
    logic [14:0]          m_head_reg;
    logic                 m_inv_reg;

    always_comb begin
        if (rh_reg < 0) begin
            hwrap = rh_reg + FULL;
        end else if (rh_reg >= FULL) begin
            hwrap = rh_reg - FULL;
        end else begin
            hwrap = rh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_pitch_reg <= invr_reg ? '0 : rp_reg[13:0];
            m_roll_reg  <= invr_reg ? '0 : rr_reg[14:0];
            m_head_reg  <= invr_reg ? '0 : hwrap[14:0];
            m_inv_reg   <= invr_reg;
        end
    end

    assign m_pitch_angle   = m_pitch_reg;
    assign m_roll_angle    = m_roll_reg;
    assign m_heading_angle = m_head_reg;
    assign m_invalid       = m_inv_reg;

`ifndef SYNTHESIS
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> m_pitch_angle == '0 && m_roll_angle == '0
                                 && m_heading_angle == '0)
        else $error("invalid result carries nonzero angles");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT-2] |-> rp_reg <= PLIM && rp_reg >= -PLIM)
        else $error("pitch outside saturation range");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT-2] |-> rh_reg <= HLIM && rh_reg >= -HLIM)
        else $error("heading outside saturation range");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[LAT-2] |=> m_valid)
        else $error("request lost at the output stage");
`endif

endmodule

### design/tcc_sqrt_cell.sv
`timescale 1ns / 1ps

module tcc_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [tcc_pkg::RAD_W-1:0]    v_in,
    input  logic [tcc_pkg::RAD_W-1:0]    r_in,
    output logic [tcc_pkg::RAD_W-1:0]    v_out,
    output logic [tcc_pkg::RAD_W-1:0]    r_out
);

    localparam logic [tcc_pkg::RAD_W-1:0] BIT = tcc_pkg::RAD_W'(1) << (2 * K);

    logic [tcc_pkg::RAD_W:0]   trial;
    logic [tcc_pkg::RAD_W-1:0] v_next, r_next, v_reg, r_reg;

    always_comb begin
        trial = {1'b0, r_in} + {1'b0, BIT};
        if ({1'b0, v_in} >= trial) begin
            v_next = v_in - trial[tcc_pkg::RAD_W-1:0];
            r_next = (r_in >> 1) + BIT;
        end else begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

### design/tcc_cordic_cell.sv
`timescale 1ns / 1ps

module tcc_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  tcc_pkg::cordic_t  d_in,
    output tcc_pkg::cordic_t  d_out
);

    localparam logic signed [tcc_pkg::Z_W-1:0] ANG = tcc_pkg::atan_entry(5'(IDX));

    tcc_pkg::cordic_t d_next, d_reg;

    always_comb begin
        // rotate toward the x axis
        if (d_in.y > 0) begin
            d_next.x = d_in.x + (d_in.y >>> IDX);
            d_next.y = d_in.y - (d_in.x >>> IDX);
            d_next.z = d_in.z + ANG;
        end else begin
            d_next.x = d_in.x - (d_in.y >>> IDX);
            d_next.y = d_in.y + (d_in.x >>> IDX);
            d_next.z = d_in.z - ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

### design/tcc_angle.sv
`timescale 1ns / 1ps

module tcc_angle #(
    parameter int STAGES = 16
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [tcc_pkg::NORM_W-1:0]   y_in,
    input  logic signed [tcc_pkg::NORM_W-1:0]   x_in,
    output logic signed [tcc_pkg::Z_W-1:0]      z_out
);

    localparam int ZW = tcc_pkg::Z_W;
    localparam int NW = tcc_pkg::NORM_W;
    localparam int CW = tcc_pkg::CX_W;
    localparam int NS = tcc_pkg::NORM_STEPS;
    localparam int META_N = NS + 3 + STAGES;
    localparam logic signed [ZW-1:0] HALF_Z =
        ZW'(tcc_pkg::HALF_TURN << tcc_pkg::INNER_FRAC);
    localparam logic signed [ZW-1:0] QUART_Z =
        ZW'(tcc_pkg::QUARTER_TURN << tcc_pkg::INNER_FRAC);

    typedef struct packed {
        logic                 spec;
        logic signed [ZW-1:0] val;
    } meta_t;

    typedef struct packed {
        logic [NW-1:0]        ux;
        logic [NW-1:0]        uy;
        logic [NW-1:0]        m;
        logic                 yneg;
        logic signed [ZW-1:0] base;
    } norm_t;

    meta_t                meta_reg [0:META_N-1];
    meta_t                meta_next;
    norm_t                norm_reg [0:NS];
    logic [NW-1:0]        a_ux_reg, a_uy_reg;
    logic                 a_yneg_reg;
    logic signed [ZW-1:0] a_base_reg;
    tcc_pkg::cordic_t     cw [0:STAGES];
    tcc_pkg::cordic_t     cin_reg;
    logic signed [ZW-1:0] z_reg;

    always_comb begin
        meta_next.spec = (y_in == '0) || (x_in == '0);
        if (y_in == '0) begin
            meta_next.val = (x_in < 0) ? HALF_Z : '0;
        end else begin
            meta_next.val = (y_in > 0) ? QUART_Z : -QUART_Z;
        end
    end

    // fold the left half-plane onto the right one
    always_ff @(posedge aclk) begin
        if (en) begin
            a_ux_reg   <= (x_in < 0) ? NW'(-x_in) : NW'(x_in);
            a_uy_reg   <= (y_in < 0) ? NW'(-y_in) : NW'(y_in);
            a_yneg_reg <= (x_in < 0) ? (y_in > 0) : (y_in < 0);
            if (x_in < 0) begin
                a_base_reg <= (y_in >= 0) ? HALF_Z : -HALF_Z;
            end else begin
                a_base_reg <= '0;
            end
            norm_reg[0].ux   <= a_ux_reg;
            norm_reg[0].uy   <= a_uy_reg;
            norm_reg[0].m    <= (a_ux_reg > a_uy_reg) ? a_ux_reg : a_uy_reg;
            norm_reg[0].yneg <= a_yneg_reg;
            norm_reg[0].base <= a_base_reg;
            meta_reg[0] <= meta_next;
            for (int k = 1; k < META_N; k++) begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // move the leading one of the larger magnitude up to the top bit
    for (genvar g = 0; g < NS; g++) begin : g_norm
        localparam int SH = 32 >> g;
        always_ff @(posedge aclk) begin
            if (en) begin
                norm_reg[g+1].yneg <= norm_reg[g].yneg;
                norm_reg[g+1].base <= norm_reg[g].base;
                if (norm_reg[g].m[NW-1 -: SH] == '0) begin
                    norm_reg[g+1].ux <= norm_reg[g].ux << SH;
                    norm_reg[g+1].uy <= norm_reg[g].uy << SH;
                    norm_reg[g+1].m  <= norm_reg[g].m << SH;
                end else begin
                    norm_reg[g+1].ux <= norm_reg[g].ux;
                    norm_reg[g+1].uy <= norm_reg[g].uy;
                    norm_reg[g+1].m  <= norm_reg[g].m;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cin_reg.x <= signed'(CW'(norm_reg[NS].ux[NW-1:NW-30]));
            cin_reg.y <= norm_reg[NS].yneg ? -signed'(CW'(norm_reg[NS].uy[NW-1:NW-30]))
                                            : signed'(CW'(norm_reg[NS].uy[NW-1:NW-30]));
            cin_reg.z <= norm_reg[NS].base;
        end
    end

    assign cw[0] = cin_reg;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        tcc_cordic_cell #(
            .IDX(g)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .d_in  (cw[g]),
            .d_out (cw[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= meta_reg[META_N-1].spec ? meta_reg[META_N-1].val : cw[STAGES].z;
        end
    end

    assign z_out = z_reg;

endmodule
